// File: hw/rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg: shared definitions for the positional list
// Sizes, command and status codes, and the request and response of the
// shared index step unit.
// ----------------------------------------------------------------------------
package plid_pkg;

  // Capacity of the list and derived widths.
  localparam int LIST_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = 7;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Request to the index step unit: step a by one and compare with b.
  typedef struct packed {
    logic             down;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } step_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] sum;
    logic             hit;
  } step_rsp_t;

endpackage

// File: hw/rtl/plid_in_if.sv
// ----------------------------------------------------------------------------
// plid_in_if: command channel of the positional list
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface plid_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [plid_pkg::CMD_W-1:0]       cmd;
  logic        [plid_pkg::CNT_W-1:0]       position;
  logic signed [plid_pkg::DATA_W-1:0]      element_value;

  modport source (output valid, output cmd, output position, output element_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input element_value,
                  output ready);
endinterface

// File: hw/rtl/plid_out_if.sv
// ----------------------------------------------------------------------------
// plid_out_if: result channel of the positional list
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface plid_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [plid_pkg::DATA_W-1:0]      item_value;
  logic        [plid_pkg::STATUS_W-1:0]    status;
  logic                                    last_flag;
  logic        [plid_pkg::CNT_W-1:0]       list_length;

  modport source (output valid, output item_value, output status, output last_flag,
                  output list_length, input ready);
  modport sink   (input valid, input item_value, input status, input last_flag,
                  input list_length, output ready);
endinterface

// File: hw/rtl/plid_ram.sv
// ----------------------------------------------------------------------------
// plid_ram: list storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plid_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [plid_pkg::ADDR_W-1:0]       waddr,
  input  logic [plid_pkg::DATA_W-1:0]       wdata,
  input  logic                              re,
  input  logic [plid_pkg::ADDR_W-1:0]       raddr,
  output logic [plid_pkg::DATA_W-1:0]       rdata
);

  logic [plid_pkg::DATA_W-1:0] mem_r [plid_pkg::LIST_DEPTH];
  logic [plid_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/plid_step.sv
// ----------------------------------------------------------------------------
// plid_step: shared index step unit
// Adds or subtracts one and compares the result with a bound.
// ----------------------------------------------------------------------------
module plid_step (
  input  plid_pkg::step_req_t req,
  output plid_pkg::step_rsp_t rsp
);

  logic [plid_pkg::CNT_W-1:0] sum;

  always_comb begin
    if (req.down) begin
      sum = req.a - plid_pkg::CNT_W'(1);
    end else begin
      sum = req.a + plid_pkg::CNT_W'(1);
    end
  end

  assign rsp.sum = sum;
  assign rsp.hit = (sum == req.b);

endmodule

// File: hw/rtl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with positional insert/delete
//
//   Channel   Dir   Handshake      Word contents
//   in_ch     in    valid/ready    cmd, position, element_value
//   out_ch    out   valid/ready    item_value, status, last_flag, list_length
//
// An insert shifts the entries from the position on back by one, then writes
// the new value into the gap; a delete shifts the entries past it forward by
// one. Shifts move one entry per cycle. A read-out streams one word per cycle
// while the result side does not stall. Errors and trivial cases go straight
// to a status word. Reset is synchronous and empties the list at once; the
// RAM contents need no clearing. Result stalls simply hold the sequencer; a
// new command is accepted while the last result still waits.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
  input  logic            clk,
  input  logic            rst_n,
  plid_in_if.sink         in_ch,
  plid_out_if.source      out_ch
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command
  localparam logic [2:0] S_INS  = 3'd1;  // moving entries back by one
  localparam logic [2:0] S_PUT  = 3'd2;  // writing the new value into the gap
  localparam logic [2:0] S_DEL  = 3'd3;  // moving entries forward by one
  localparam logic [2:0] S_RD   = 3'd4;  // streaming entries to the result side
  localparam logic [2:0] S_DONE = 3'd5;  // issuing a single status word

  localparam int AW = plid_pkg::ADDR_W;
  localparam int CW = plid_pkg::CNT_W;
  localparam int DW = plid_pkg::DATA_W;

  logic [2:0]                   state_r,  state_nxt;
  logic [CW-1:0]                count_r,  count_nxt;
  logic [AW-1:0]                idx_r,    idx_nxt;
  logic [AW-1:0]                wr_r,     wr_nxt;
  logic [AW-1:0]                pos_r,    pos_nxt;
  logic [DW-1:0]                value_r,  value_nxt;
  logic [plid_pkg::STATUS_W-1:0] st_r,    st_nxt;

  logic                          out_valid_r,  out_valid_nxt;
  logic [DW-1:0]                 out_value_r,  out_value_nxt;
  logic [plid_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                          out_last_r,   out_last_nxt;
  logic [CW-1:0]                 out_len_r,    out_len_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  plid_pkg::step_req_t step_req;
  plid_pkg::step_rsp_t step_rsp;

  logic in_acc;
  logic slot_free;

  plid_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one index unit serves every walk through the list: it computes the next
  // address and tells the sequencer when a delete or read-out walk ends.
  plid_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);

  // The output register can take a new word if it is empty or being drained.
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    pos_nxt        = pos_r;
    value_nxt      = value_r;
    st_nxt         = st_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_len_nxt    = out_len_r;

    ram_we         = 1'b0;
    ram_waddr      = wr_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = step_rsp.sum[AW-1:0];

    step_req.down  = 1'b0;
    step_req.a     = CW'(idx_r);
    step_req.b     = count_r;

    unique case (state_r)
      S_IDLE: begin
        // An insert walks down from the tail; a delete starts just past the
        // removed entry and compares against the length.
        if (in_ch.cmd == plid_pkg::CMD_INSERT) begin
          step_req.down = 1'b1;
          step_req.a    = count_r;
        end else begin
          step_req.a    = in_ch.position;
        end
        if (in_acc) begin
          pos_nxt   = in_ch.position[AW-1:0];
          value_nxt = in_ch.element_value;
          unique case (in_ch.cmd)
            plid_pkg::CMD_INSERT: begin
              if (in_ch.position > count_r) begin
                st_nxt    = plid_pkg::ST_RANGE;
                state_nxt = S_DONE;
              end else if (count_r == CW'(plid_pkg::LIST_DEPTH)) begin
                st_nxt    = plid_pkg::ST_FULL;
                state_nxt = S_DONE;
              end else if (in_ch.position == count_r) begin
                // Append at the tail: nothing to move.
                ram_we    = 1'b1;
                ram_waddr = in_ch.position[AW-1:0];
                ram_wdata = in_ch.element_value;
                count_nxt = count_r + CW'(1);
                st_nxt    = plid_pkg::ST_OK;
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                idx_nxt   = step_rsp.sum[AW-1:0];
                wr_nxt    = count_r[AW-1:0];
                state_nxt = S_INS;
              end
            end
            plid_pkg::CMD_DELETE: begin
              if (count_r == '0) begin
                st_nxt    = plid_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else if (in_ch.position >= count_r) begin
                st_nxt    = plid_pkg::ST_RANGE;
                state_nxt = S_DONE;
              end else if (step_rsp.hit) begin
                // Removing the tail: nothing to move.
                count_nxt = count_r - CW'(1);
                st_nxt    = plid_pkg::ST_OK;
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                idx_nxt   = step_rsp.sum[AW-1:0];
                wr_nxt    = in_ch.position[AW-1:0];
                state_nxt = S_DEL;
              end
            end
            plid_pkg::CMD_READ: begin
              if (count_r == '0) begin
                st_nxt    = plid_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            plid_pkg::CMD_NONE: begin
              // Unused code: swallowed without a result.
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // The entry read last cycle lands one place further back, while the
        // next one down is read.
        step_req.down = 1'b1;
        ram_we        = 1'b1;
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = step_rsp.sum[AW-1:0];
          wr_nxt  = idx_r;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = value_r;
        count_nxt = count_r + CW'(1);
        st_nxt    = plid_pkg::ST_OK;
        state_nxt = S_DONE;
      end

      S_DEL: begin
        // The entry read last cycle lands one place further forward.
        ram_we = 1'b1;
        if (step_rsp.hit) begin
          count_nxt = count_r - CW'(1);
          st_nxt    = plid_pkg::ST_OK;
          state_nxt = S_DONE;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = step_rsp.sum[AW-1:0];
          wr_nxt  = idx_r;
        end
      end

      S_RD: begin
        // The read data holds until the output register takes it.
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ram_rdata;
          out_status_nxt = plid_pkg::ST_OK;
          out_last_nxt   = step_rsp.hit;
          out_len_nxt    = count_r;
          if (step_rsp.hit) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re  = 1'b1;
            idx_nxt = step_rsp.sum[AW-1:0];
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = st_r;
          out_last_nxt   = 1'b1;
          out_len_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    wr_r         <= wr_nxt;
    pos_r        <= pos_nxt;
    value_r      <= value_nxt;
    st_r         <= st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.item_value  = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_flag   = out_last_r;
  assign out_ch.list_length = out_len_r;

endmodule

// File: hw/rtl/plid_checker.sv
// ----------------------------------------------------------------------------
// plid_checker: port-level checks for the positional list
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module plid_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [plid_pkg::CMD_W-1:0]          in_cmd,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [plid_pkg::DATA_W-1:0]         out_item_value,
  input logic [plid_pkg::STATUS_W-1:0]       out_status,
  input logic                                out_last_flag,
  input logic [plid_pkg::CNT_W-1:0]          out_list_length
);

  // Reset leaves no result word pending.
  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Every real command keeps the block busy for at least the next cycle.
  a_busy_after_command: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != plid_pkg::CMD_NONE) |=> !in_ready)
    else $error("command accepted back to back");

  // A word that is not OK is a status word: zero value and final.
  a_status_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != plid_pkg::ST_OK) |-> out_last_flag && (out_item_value == '0))
    else $error("malformed status word");

  // The reported length never exceeds the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_list_length <= plid_pkg::CNT_W'(plid_pkg::LIST_DEPTH)))
    else $error("list length beyond capacity");

  // A stalled result word holds still.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value) && $stable(out_status)
      && $stable(out_last_flag) && $stable(out_list_length))
    else $error("stalled result word changed");

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_item_value  (out_ch.item_value),
  .out_status      (out_ch.status),
  .out_last_flag   (out_ch.last_flag),
  .out_list_length (out_ch.list_length)
);
